FILE: hdl/vcd_pkg.sv
// Shared types, constants and helper functions of the VIN check digit validator.
// Used by every module in hdl/; depends on nothing.
package vcd_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned PosW       = 5;
  localparam int unsigned ResidW     = 4;
  localparam int unsigned ExpectW    = 7;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 16;

  localparam logic [PosW-1:0]    VinLast   = 5'd16;  // position of the seventeenth character
  localparam logic [PosW-1:0]    VinLen    = 5'd17;
  localparam logic [PosW-1:0]    CheckPos  = 5'd8;
  localparam logic [PosW-1:0]    PosMax    = 5'd31;
  localparam logic [ResidW-1:0]  VinMod    = 4'd11;
  localparam logic [ExpectW-1:0] AsciiZero = 7'h30;
  localparam logic [ExpectW-1:0] AsciiX    = 7'h58;

  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic [StatusW-1:0] {
    StatusOk       = 2'd0,
    StatusBadCheck = 2'd1,
    StatusBadLen   = 2'd2,
    StatusBadChar  = 2'd3
  } status_e;

  // Transliteration of a letter, indexed by the low five bits of its code.
  localparam logic [3:0] LetterValue [32] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd0,
    4'd7, 4'd0, 4'd9, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
    4'd7, 4'd8, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  // Classified character, handed from the front end to the back end.
  typedef struct packed {
    logic [ResidW-1:0] term;       // weighted value modulo 11
    logic              bad;        // disallowed character at a weighted position
    logic              is_check;   // ninth character
    logic [CharW-1:0]  char_code;
    logic              len_ok;     // this character is the seventeenth
    logic              last;
  } item_t;

  function automatic logic [3:0] weight_of(input logic [PosW-1:0] pos);
    logic [3:0] w;
    if (pos < 5'd7) begin
      w = 4'(5'd8 - pos);
    end else if (pos == 5'd7) begin
      w = 4'd10;
    end else begin
      w = 4'(5'd18 - pos);
    end
    return w;
  endfunction

  // Remainder modulo 11 of a value up to 100, by restoring subtraction.
  function automatic logic [ResidW-1:0] mod11(input logic [6:0] x);
    logic [6:0] r;
    r = x;
    if (r >= 7'd88) r = r - 7'd88;
    if (r >= 7'd44) r = r - 7'd44;
    if (r >= 7'd22) r = r - 7'd22;
    if (r >= 7'd11) r = r - 7'd11;
    return r[ResidW-1:0];
  endfunction

endpackage

FILE: hdl/vin_check_digit_validator.sv
// Top level of the VIN check digit validator (ISO 3779 weighting, modulo 11).
// Depends on vcd_pkg, vcd_front, vcd_fifo and vcd_back.
//
//   Slave stream: one ASCII character per transaction in s_axis_tdata, with
//   s_axis_tlast high on the final character of an identifier.
//   Master stream: one verdict per identifier, issued after its final
//   character: status (conformant, wrong check digit, wrong length, bad
//   character) and the computed check character ('0'..'9' or 'X', zero
//   when the status is wrong length or bad character).
//   Throughput: one character per cycle while the queue has room; a final
//   character held on the master side stops the queue. The verdict for a
//   final character passes through the front end into the queue, then
//   through the back end into the output register.
//   The front end classifies and weights each character against its own
//   position counter; a queue of QueueDepth entries lets it run ahead while
//   the back end holds a verdict that the receiver has not taken.
//   Receiver stall: the back end keeps consuming non-final characters and
//   stops only on a final one; once the queue fills, s_axis_tready drops.
//   Reset: clears the position, residue, flags, queue and output valid; the
//   next character is taken as the first of a new identifier.
module vin_check_digit_validator #(
  parameter int unsigned QueueDepth = vcd_pkg::QueueDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [vcd_pkg::InDataW-1:0]  s_axis_tdata,   // [7:0] char_code
  input  logic                         s_axis_tlast,   // last_char
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [vcd_pkg::OutDataW-1:0] m_axis_tdata    // [1:0] status, [8:2] expected_check
);

  logic           push, full, pop, q_valid;
  vcd_pkg::item_t front_item, back_item;

  // Classify and weight each incoming character.
  vcd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .full_i        (full),
    .push_o        (push),
    .item_o        (front_item)
  );

  // Decouple classification from accumulation.
  vcd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (back_item)
  );

  // Accumulate and issue the verdict.
  vcd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .item_i        (back_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: hdl/vcd_front.sv
// Front end: counts positions, transliterates and weights each character.
// Depends on vcd_pkg.
module vcd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [vcd_pkg::CharW-1:0] s_axis_tdata,
  input  logic                      s_axis_tlast,
  input  logic                      full_i,
  output logic                      push_o,
  output vcd_pkg::item_t            item_o
);

  logic [vcd_pkg::PosW-1:0] pos_q, pos_d;
  logic [vcd_pkg::CharW-1:0] c;
  logic       is_letter, is_digit, ok, weighted;
  logic [3:0] value;
  logic [7:0] product;

  assign c             = s_axis_tdata;
  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  always_comb begin
    is_letter = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    is_digit  = (c >= 8'h30 && c <= 8'h39);
    ok        = 1'b0;
    value     = '0;
    if (is_letter) begin
      // I, O and Q have no transliteration
      ok    = !(c[4:0] == 5'd9 || c[4:0] == 5'd15 || c[4:0] == 5'd17);
      value = ok ? vcd_pkg::LetterValue[c[4:0]] : 4'd0;
    end else if (is_digit) begin
      ok    = 1'b1;
      value = c[3:0];
    end
    weighted = (pos_q < vcd_pkg::VinLen) && (pos_q != vcd_pkg::CheckPos);
    product  = value * vcd_pkg::weight_of(pos_q);

    item_o.term      = weighted ? vcd_pkg::mod11(product[6:0]) : '0;
    item_o.bad       = weighted && !ok;
    item_o.is_check  = (pos_q == vcd_pkg::CheckPos);
    item_o.char_code = c;
    item_o.len_ok    = (pos_q == vcd_pkg::VinLast);
    item_o.last      = s_axis_tlast;
  end

  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (s_axis_tlast) begin
        pos_d = '0;
      end else if (pos_q != vcd_pkg::PosMax) begin
        pos_d = pos_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

FILE: hdl/vcd_fifo.sv
// Short queue of classified characters between front and back end.
// Depends on vcd_pkg; Depth must be a power of two.
module vcd_fifo #(
  parameter int unsigned Depth = vcd_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vcd_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output vcd_pkg::item_t item_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  vcd_pkg::item_t mem_q [Depth];
  logic [AddrW:0] wr_q, wr_d, rd_q, rd_d;

  assign full_o  = (wr_q[AddrW-1:0] == rd_q[AddrW-1:0]) && (wr_q[AddrW] != rd_q[AddrW]);
  assign valid_o = (wr_q != rd_q);
  assign item_o  = mem_q[rd_q[AddrW-1:0]];

  assign wr_d = push_i ? wr_q + 1'b1 : wr_q;
  assign rd_d = pop_i  ? rd_q + 1'b1 : rd_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[AddrW-1:0]] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

endmodule

FILE: hdl/vcd_back.sv
// Back end: accumulates the residue, keeps the check character, issues the verdict.
// Depends on vcd_pkg.
module vcd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  vcd_pkg::item_t               item_i,
  output logic                         pop_o,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [vcd_pkg::OutDataW-1:0] m_axis_tdata
);

  logic [vcd_pkg::ResidW-1:0]  resid_q, resid_d;
  logic                        bad_q, bad_d;
  logic [vcd_pkg::CharW-1:0]   given_q, given_d;
  logic                        out_valid_q, out_valid_d;
  vcd_pkg::status_e            status_q, status_d;
  logic [vcd_pkg::ExpectW-1:0] expect_q, expect_d;
  logic [vcd_pkg::ResidW:0]    sum;
  logic [vcd_pkg::ResidW-1:0]  resid_new;
  logic [vcd_pkg::ExpectW-1:0] expect_new;
  logic                        bad_new;
  logic [vcd_pkg::CharW-1:0]   given_new;

  // Non-final characters never wait; a final one waits for a free output slot.
  assign pop_o = valid_i && (!item_i.last || !out_valid_q || m_axis_tready);

  always_comb begin
    sum        = {1'b0, resid_q} + {1'b0, item_i.term};
    resid_new  = (sum >= {1'b0, vcd_pkg::VinMod}) ?
                 vcd_pkg::ResidW'(sum - {1'b0, vcd_pkg::VinMod}) : sum[vcd_pkg::ResidW-1:0];
    bad_new    = bad_q || item_i.bad;
    given_new  = item_i.is_check ? item_i.char_code : given_q;
    expect_new = (resid_new < 4'd10) ?
                 vcd_pkg::AsciiZero + {3'b000, resid_new} : vcd_pkg::AsciiX;

    resid_d     = resid_q;
    bad_d       = bad_q;
    given_d     = given_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    status_d    = status_q;
    expect_d    = expect_q;

    if (pop_o) begin
      if (item_i.last) begin
        // clear the running state for the next identifier
        resid_d     = '0;
        bad_d       = 1'b0;
        given_d     = '0;
        out_valid_d = 1'b1;
        expect_d    = '0;
        if (!item_i.len_ok) begin
          status_d = vcd_pkg::StatusBadLen;
        end else if (bad_new) begin
          status_d = vcd_pkg::StatusBadChar;
        end else begin
          expect_d = expect_new;
          status_d = (given_new == {1'b0, expect_new}) ? vcd_pkg::StatusOk
                                                       : vcd_pkg::StatusBadCheck;
        end
      end else begin
        resid_d = resid_new;
        bad_d   = bad_new;
        given_d = given_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resid_q     <= '0;
      bad_q       <= 1'b0;
      given_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      resid_q     <= resid_d;
      bad_q       <= bad_d;
      given_q     <= given_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    expect_q <= expect_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, expect_q, status_q};

endmodule
